// ----- sv/dst_pkg.sv -----
// Package for the decoder state table: sizes, codes, and shared structs.
`default_nettype none
package dst_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [13:0] LONG_ADDR_MIN = 14'd100;
  localparam logic [7:0] STEPS_14 = 8'd14;
  localparam logic [7:0] STEPS_28 = 8'd28;
  localparam logic [7:0] STEPS_128 = 8'd128;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_STEPS = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  typedef enum logic [2:0] {
    CMD_LOOKUP = 3'd0,
    CMD_SET_SPEED = 3'd1,
    CMD_SET_FUNC = 3'd2,
    CMD_SET_ACC = 3'd3,
    CMD_UNSET_ACC = 3'd4,
    CMD_ESTOP_ONE = 3'd5,
    CMD_ESTOP_ALL = 3'd6,
    CMD_CLEAR = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ZSCAN,
    ST_UPDATE,
    ST_READ
  } state_t;

  // Write request into the entry store.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic we_address;
    logic we_func;
    logic we_speed;
    logic we_steps;
    logic [13:0] address;
    logic [15:0] func;
    logic signed [7:0] speed;
    logic [7:0] steps;
    logic clr_speeds;
    logic [CNT_W-1:0] clr_count;
  } table_wr_t;

  // One entry as read from the store.
  typedef struct packed {
    logic [13:0] address;
    logic [15:0] func;
    logic signed [7:0] speed;
    logic [7:0] steps;
  } entry_t;

  // One result beat.
  typedef struct packed {
    logic [3:0] slot_index;
    logic [1:0] status;
    logic long_form;
    logic signed [7:0] entry_speed;
    logic [7:0] entry_steps;
    logic [15:0] entry_functions;
    logic [4:0] entry_count;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/dst_cmd_if.sv -----
// Command channel: valid/ready handshake carrying one command beat.
`default_nettype none
interface dst_cmd_if;
  logic valid;
  logic ready;
  logic [2:0] command;
  logic [13:0] decoder_address;
  logic signed [7:0] speed_value;
  logic [7:0] step_mode;
  logic [15:0] function_bits;
  logic scheduler_ok;

  modport source (output valid, command, decoder_address, speed_value, step_mode,
                  function_bits, scheduler_ok, input ready);
  modport sink (input valid, command, decoder_address, speed_value, step_mode,
                function_bits, scheduler_ok, output ready);
endinterface
`default_nettype wire

// ----- sv/dst_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result beat.
`default_nettype none
interface dst_rsp_if;
  logic valid;
  logic ready;
  logic [3:0] slot_index;
  logic [1:0] status;
  logic long_form;
  logic signed [7:0] entry_speed;
  logic [7:0] entry_steps;
  logic [15:0] entry_functions;
  logic [4:0] entry_count;

  modport source (output valid, slot_index, status, long_form, entry_speed, entry_steps,
                  entry_functions, entry_count, input ready);
  modport sink (input valid, slot_index, status, long_form, entry_speed, entry_steps,
                entry_functions, entry_count, output ready);
endinterface
`default_nettype wire

// ----- sv/dst_table.sv -----
// Entry store: one write port, one read port, and a bulk speed clear.
`default_nettype none
module dst_table
  import dst_pkg::*;
(
  input wire logic clk,
  input wire table_wr_t wr,
  input wire logic [IDX_W-1:0] rd_idx,
  output entry_t rd_entry
);

  logic [13:0] address_store [TABLE_DEPTH];
  logic [15:0] func_store [TABLE_DEPTH];
  logic signed [7:0] speed_store [TABLE_DEPTH];
  logic [7:0] steps_store [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (wr.clr_speeds && (CNT_W'(i) < wr.clr_count)) begin
        speed_store[i] <= 8'sd0;
      end else if (wr.we_speed && (wr.idx == IDX_W'(i))) begin
        speed_store[i] <= wr.speed;
      end
    end
    if (wr.we_address) begin
      address_store[wr.idx] <= wr.address;
    end
    if (wr.we_func) begin
      func_store[wr.idx] <= wr.func;
    end
    if (wr.we_steps) begin
      steps_store[wr.idx] <= wr.steps;
    end
  end

  always_comb begin
    rd_entry.address = address_store[rd_idx];
    rd_entry.func = func_store[rd_idx];
    rd_entry.speed = speed_store[rd_idx];
    rd_entry.steps = steps_store[rd_idx];
  end

endmodule
`default_nettype wire

// ----- sv/dst_ctrl.sv -----
// Sequencer: address search through a single read port, allocation and entry update.
`default_nettype none
module dst_ctrl
  import dst_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  dst_cmd_if.sink cmd,
  input wire logic out_busy,
  input wire entry_t rd_entry,
  output logic [IDX_W-1:0] rd_idx,
  output table_wr_t wr,
  output result_t res,
  output logic res_load
);

  state_t state, state_next;

  cmd_t cmd_r;
  logic [13:0] addr_r;
  logic signed [7:0] speed_r;
  logic [7:0] steps_r;
  logic [15:0] funcs_r;
  logic ok_r;
  logic [1:0] status_r;
  logic long_form_r;

  logic [CNT_W-1:0] used_count, used_count_next;
  logic [IDX_W-1:0] last_hit, last_hit_next;
  logic [CNT_W-1:0] replace_pointer, replace_pointer_next;
  logic [IDX_W-1:0] scan_ptr, scan_ptr_next;
  logic [CNT_W-1:0] scan_cnt, scan_cnt_next;
  logic [IDX_W-1:0] slot, slot_next;
  logic alloc, alloc_next;

  cmd_t in_cmd;
  logic steps_valid;
  logic in_ok;
  logic [IDX_W-1:0] rr_slot;
  logic show;

  assign in_cmd = cmd_t'(cmd.command);
  assign steps_valid = (cmd.step_mode == STEPS_14) || (cmd.step_mode == STEPS_28) ||
                       (cmd.step_mode == STEPS_128);
  assign cmd.ready = (state == ST_IDLE);
  assign in_ok = cmd.valid && cmd.ready;
  assign rr_slot = (replace_pointer >= used_count) ? '0 : replace_pointer[IDX_W-1:0];
  assign show = (CNT_W'(slot) < used_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used_count <= '0;
      last_hit <= '0;
      replace_pointer <= '0;
    end else begin
      state <= state_next;
      used_count <= used_count_next;
      last_hit <= last_hit_next;
      replace_pointer <= replace_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr <= scan_ptr_next;
    scan_cnt <= scan_cnt_next;
    slot <= slot_next;
    alloc <= alloc_next;
    if (in_ok) begin
      cmd_r <= in_cmd;
      addr_r <= cmd.decoder_address;
      speed_r <= cmd.speed_value;
      steps_r <= cmd.step_mode;
      funcs_r <= cmd.function_bits;
      ok_r <= cmd.scheduler_ok;
      long_form_r <= (in_cmd != CMD_ESTOP_ALL) && (in_cmd != CMD_CLEAR) &&
                     (cmd.decoder_address >= LONG_ADDR_MIN);
      if (in_cmd == CMD_LOOKUP || in_cmd == CMD_CLEAR) begin
        status_r <= STATUS_OK;
      end else if (in_cmd == CMD_SET_SPEED && !steps_valid) begin
        status_r <= STATUS_BAD_STEPS;
      end else begin
        status_r <= cmd.scheduler_ok ? STATUS_OK : STATUS_REFUSED;
      end
    end
  end

  always_comb begin
    state_next = state;
    used_count_next = used_count;
    last_hit_next = last_hit;
    replace_pointer_next = replace_pointer;
    scan_ptr_next = scan_ptr;
    scan_cnt_next = scan_cnt;
    slot_next = slot;
    alloc_next = alloc;
    rd_idx = scan_ptr;
    wr = '0;
    wr.idx = slot;
    res_load = 1'b0;
    res.slot_index = 4'(slot);
    res.status = status_r;
    res.long_form = long_form_r;
    res.entry_speed = show ? rd_entry.speed : 8'sd0;
    res.entry_steps = show ? rd_entry.steps : 8'd0;
    res.entry_functions = show ? rd_entry.func : 16'd0;
    res.entry_count = 5'(used_count);

    unique case (state)
      ST_IDLE: begin
        if (in_ok) begin
          alloc_next = 1'b0;
          if (in_cmd == CMD_CLEAR) begin
            used_count_next = '0;
            last_hit_next = '0;
            slot_next = '0;
            state_next = ST_READ;
          end else if (in_cmd == CMD_ESTOP_ALL) begin
            wr.clr_speeds = 1'b1;
            wr.clr_count = used_count;
            slot_next = last_hit;
            state_next = ST_READ;
          end else if (in_cmd == CMD_SET_SPEED && !steps_valid) begin
            slot_next = last_hit;
            state_next = ST_READ;
          end else if (used_count == '0) begin
            slot_next = '0;
            last_hit_next = '0;
            alloc_next = 1'b1;
            state_next = ST_UPDATE;
          end else begin
            scan_ptr_next = last_hit;
            scan_cnt_next = '0;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_idx = scan_ptr;
        if (rd_entry.address == addr_r) begin
          slot_next = scan_ptr;
          last_hit_next = scan_ptr;
          state_next = ST_UPDATE;
        end else if (scan_cnt + 1'b1 == used_count) begin
          if (used_count < CNT_W'(TABLE_DEPTH)) begin
            slot_next = used_count[IDX_W-1:0];
            last_hit_next = used_count[IDX_W-1:0];
            alloc_next = 1'b1;
            state_next = ST_UPDATE;
          end else begin
            scan_ptr_next = '0;
            state_next = ST_ZSCAN;
          end
        end else begin
          scan_cnt_next = scan_cnt + 1'b1;
          scan_ptr_next = (CNT_W'(scan_ptr) + 1'b1 == used_count) ? '0 : scan_ptr + 1'b1;
        end
      end
      ST_ZSCAN: begin
        // The table is full here; look for a slot holding address zero.
        rd_idx = scan_ptr;
        if (rd_entry.address == 14'd0) begin
          slot_next = scan_ptr;
          last_hit_next = scan_ptr;
          alloc_next = 1'b1;
          state_next = ST_UPDATE;
        end else if (scan_ptr == IDX_W'(TABLE_DEPTH - 1)) begin
          slot_next = rr_slot;
          last_hit_next = rr_slot;
          replace_pointer_next = CNT_W'(rr_slot) + 1'b1;
          alloc_next = 1'b1;
          state_next = ST_UPDATE;
        end else begin
          scan_ptr_next = scan_ptr + 1'b1;
        end
      end
      ST_UPDATE: begin
        wr.address = addr_r;
        wr.we_address = alloc;
        wr.speed = (ok_r && cmd_r == CMD_SET_SPEED) ? speed_r : 8'sd0;
        wr.we_speed = alloc || (ok_r && (cmd_r == CMD_SET_SPEED || cmd_r == CMD_ESTOP_ONE));
        wr.steps = (ok_r && cmd_r == CMD_SET_SPEED) ? steps_r : 8'd0;
        wr.we_steps = alloc || (ok_r && cmd_r == CMD_SET_SPEED);
        wr.func = 16'd0;
        wr.we_func = alloc;
        if (ok_r) begin
          case (cmd_r)
            CMD_SET_FUNC: begin
              wr.func = funcs_r;
              wr.we_func = 1'b1;
            end
            CMD_SET_ACC: begin
              wr.func = {8'h00, funcs_r[7:0]};
              wr.we_func = 1'b1;
            end
            CMD_UNSET_ACC: begin
              wr.func = {8'hFF, ~funcs_r[7:0]};
              wr.we_func = 1'b1;
            end
            default: begin
            end
          endcase
        end
        if (alloc && (CNT_W'(slot) == used_count)) begin
          used_count_next = used_count + 1'b1;
        end
        state_next = ST_READ;
      end
      ST_READ: begin
        rd_idx = slot;
        if (!out_busy) begin
          res_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/decoder_state_table_unit.sv -----
// Top level of the decoder state table: sequencer, entry store and result register.
// Path from the accepting edge to a valid result beat: clear, estop all and a bad step count
// go straight to the read state; an empty table goes through the update state; a hit or an
// append scans for the address, then updates; a miss on a full table walks the table for
// the address and again for a free slot, one slot per cycle, then updates and reads.
// The next command is taken in the cycle after the result is loaded, so commands do not
// overlap; a result still waiting on the response channel holds the sequencer.
// Reset (synchronous, active high) empties the table; entry contents stay undefined.
`default_nettype none
module decoder_state_table_unit
  import dst_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  dst_cmd_if.sink cmd,
  dst_rsp_if.source rsp
);

  // Storage and sequencer talk through a write struct and one read port.
  table_wr_t wr;
  entry_t rd_entry;
  logic [IDX_W-1:0] rd_idx;
  result_t res;
  result_t res_r;
  logic res_load;
  logic rsp_valid;
  logic out_busy;

  // The sequencer holds its finished result while the previous beat still waits.
  assign out_busy = rsp_valid && !rsp.ready;

  dst_table u_table (
    .clk(clk),
    .wr(wr),
    .rd_idx(rd_idx),
    .rd_entry(rd_entry)
  );

  dst_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .out_busy(out_busy),
    .rd_entry(rd_entry),
    .rd_idx(rd_idx),
    .wr(wr),
    .res(res),
    .res_load(res_load)
  );

  // Result register: valid is set on a load and cleared when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.slot_index = res_r.slot_index;
  assign rsp.status = res_r.status;
  assign rsp.long_form = res_r.long_form;
  assign rsp.entry_speed = res_r.entry_speed;
  assign rsp.entry_steps = res_r.entry_steps;
  assign rsp.entry_functions = res_r.entry_functions;
  assign rsp.entry_count = res_r.entry_count;

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the decoder state table: directed table, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dst_pkg::*;

  // One command beat as the testbench builds it before driving the channel.
  typedef struct packed {
    cmd_t cmd;
    logic [13:0] addr;
    logic signed [7:0] speed;
    logic [7:0] steps;
    logic [15:0] funcs;
    logic ok;
  } cmd_beat_t;

  // A row of the directed table. When known is set, want is the result read straight
  // off the behavior; otherwise the table predictor supplies the expectation.
  typedef struct packed {
    cmd_beat_t beat;
    logic known;
    result_t want;
  } stim_row_t;

  localparam result_t NO_WANT = '0;
  localparam int N_DIRECTED = 23;
  localparam int N_ITEMS = 1700;
  localparam int N_RANDOM = N_ITEMS - N_DIRECTED;
  // The last stretch of the run is driven and drained with no idling at all.
  localparam int QUIET_TAIL = 150;
  // Long receiver hold-off, counted in cycles by the receiver process.
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT = 300;
  // Point at which the sender stops until every outstanding result has come back.
  localparam int PAUSE_AT = 800;
  // Tail wait after the drain; it covers a full-table miss with margin.
  localparam int TAIL_CYCLES = 40;
  localparam int DRAIN_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dst_cmd_if cmd_ch ();
  dst_rsp_if rsp_ch ();

  decoder_state_table_unit DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Table predictor. It mirrors the decoder table: per-slot address, function
  // word, speed and step count, plus the number of slots in use, the slot of the
  // last hit (where the next search starts) and the round-robin victim pointer.
  // ---------------------------------------------------------------------------
  logic [13:0] tbl_addr [TABLE_DEPTH];
  logic [15:0] tbl_func [TABLE_DEPTH];
  logic signed [7:0] tbl_speed [TABLE_DEPTH];
  logic [7:0] tbl_steps [TABLE_DEPTH];
  int unsigned used_n = 0;
  int unsigned last_slot = 0;
  int unsigned rr_ptr = 0;

  // Results still owed by the block, oldest first.
  result_t expected_results [$];
  int fail_count = 0;

  // A freshly allocated entry carries the address and nothing else.
  function automatic void seed_entry(int unsigned slot, logic [13:0] addr);
    tbl_addr[slot] = addr;
    tbl_func[slot] = '0;
    tbl_speed[slot] = '0;
    tbl_steps[slot] = '0;
  endfunction

  // Find the address, or allocate a slot for it, and return the slot.
  function automatic int unsigned locate_slot(logic [13:0] addr);
    int unsigned start;
    int unsigned p;
    // The search begins at the last hit (clamped to the used part) and wraps.
    start = (last_slot < used_n) ? last_slot : used_n;
    for (p = start; p < used_n; p++) begin
      if (tbl_addr[p] == addr) begin
        last_slot = p;
        return p;
      end
    end
    for (p = 0; p < start; p++) begin
      if (tbl_addr[p] == addr) begin
        last_slot = p;
        return p;
      end
    end
    // Miss: append while there is room.
    if (used_n < TABLE_DEPTH) begin
      p = used_n;
      seed_entry(p, addr);
      used_n++;
      last_slot = p;
      return p;
    end
    // Full: the first slot holding address zero is taken as free.
    for (p = 0; p < used_n; p++) begin
      if (tbl_addr[p] == 14'd0) begin
        seed_entry(p, addr);
        last_slot = p;
        return p;
      end
    end
    // Otherwise the round-robin pointer picks the victim, wrapping at the used count.
    if (rr_ptr >= used_n) begin
      rr_ptr = 0;
    end
    p = rr_ptr;
    seed_entry(p, addr);
    last_slot = p;
    rr_ptr = p + 1;
    return p;
  endfunction

  // Apply one accepted command to the predictor and return the result it causes.
  function automatic result_t predict_beat(cmd_beat_t b);
    result_t r;
    int unsigned slot;
    int unsigned i;
    logic lf;
    logic [1:0] st;
    logic show;
    lf = (b.addr >= LONG_ADDR_MIN);
    st = b.ok ? STATUS_OK : STATUS_REFUSED;
    show = 1'b1;
    slot = 0;
    case (b.cmd)
      CMD_LOOKUP: begin
        slot = locate_slot(b.addr);
        st = STATUS_OK;
      end
      CMD_SET_SPEED: begin
        // A bad step count skips the lookup entirely and reports the last hit.
        if (b.steps != STEPS_14 && b.steps != STEPS_28 && b.steps != STEPS_128) begin
          slot = last_slot;
          st = STATUS_BAD_STEPS;
        end else begin
          slot = locate_slot(b.addr);
          if (b.ok) begin
            tbl_speed[slot] = b.speed;
            tbl_steps[slot] = b.steps;
          end
        end
      end
      CMD_SET_FUNC: begin
        slot = locate_slot(b.addr);
        if (b.ok) tbl_func[slot] = b.funcs;
      end
      CMD_SET_ACC: begin
        slot = locate_slot(b.addr);
        if (b.ok) tbl_func[slot] = {8'h00, b.funcs[7:0]};
      end
      CMD_UNSET_ACC: begin
        slot = locate_slot(b.addr);
        if (b.ok) tbl_func[slot] = {8'hFF, ~b.funcs[7:0]};
      end
      CMD_ESTOP_ONE: begin
        slot = locate_slot(b.addr);
        if (b.ok) tbl_speed[slot] = '0;
      end
      CMD_ESTOP_ALL: begin
        // Every used speed is zeroed even when the scheduler refused.
        for (i = 0; i < used_n; i++) tbl_speed[i] = '0;
        slot = last_slot;
        lf = 1'b0;
      end
      default: begin
        // Clear keeps the round-robin pointer and the stale entry contents.
        used_n = 0;
        last_slot = 0;
        show = 1'b0;
        lf = 1'b0;
        st = STATUS_OK;
      end
    endcase
    r.slot_index = slot[3:0];
    r.status = st;
    r.long_form = lf;
    if (show && slot < used_n) begin
      r.entry_speed = tbl_speed[slot];
      r.entry_steps = tbl_steps[slot];
      r.entry_functions = tbl_func[slot];
    end else begin
      r.entry_speed = '0;
      r.entry_steps = '0;
      r.entry_functions = '0;
    end
    r.entry_count = used_n[4:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed part: extremes of every field, every command, refused and bad step
  // counts, estop all on an empty table, clear, and re-allocation after clear.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [N_DIRECTED] = '{
    // Estop all on an empty table reports slot zero with zeroed entry fields.
    '{'{CMD_ESTOP_ALL, 14'h2AAA, 8'sd0, 8'd0, 16'h0000, 1'b1}, 1'b1,
      '{4'd0, STATUS_OK, 1'b0, 8'sd0, 8'd0, 16'h0000, 5'd0}},
    // A step count of zero is rejected without a lookup.
    '{'{CMD_SET_SPEED, 14'd5, 8'sd0, 8'd0, 16'h0000, 1'b1}, 1'b1,
      '{4'd0, STATUS_BAD_STEPS, 1'b0, 8'sd0, 8'd0, 16'h0000, 5'd0}},
    '{'{CMD_LOOKUP, 14'd0, 8'sd0, 8'd0, 16'h0000, 1'b1}, 1'b1,
      '{4'd0, STATUS_OK, 1'b0, 8'sd0, 8'd0, 16'h0000, 5'd1}},
    '{'{CMD_SET_SPEED, 14'h3FFF, -8'sd128, STEPS_128, 16'h0000, 1'b1}, 1'b1,
      '{4'd1, STATUS_OK, 1'b1, -8'sd128, STEPS_128, 16'h0000, 5'd2}},
    // 99 is the highest short address, 100 the lowest long one.
    '{'{CMD_SET_SPEED, 14'd99, 8'sd127, STEPS_14, 16'h0000, 1'b1}, 1'b1,
      '{4'd2, STATUS_OK, 1'b0, 8'sd127, STEPS_14, 16'h0000, 5'd3}},
    '{'{CMD_SET_SPEED, 14'd100, 8'sd1, STEPS_28, 16'h0000, 1'b0}, 1'b1,
      '{4'd3, STATUS_REFUSED, 1'b1, 8'sd0, 8'd0, 16'h0000, 5'd4}},
    '{'{CMD_SET_FUNC, 14'd99, 8'sd0, 8'd0, 16'hFFFF, 1'b1}, 1'b1,
      '{4'd2, STATUS_OK, 1'b0, 8'sd127, STEPS_14, 16'hFFFF, 5'd4}},
    // Set accessory keeps only the low byte.
    '{'{CMD_SET_ACC, 14'd99, 8'sd0, 8'd0, 16'hA5C3, 1'b1}, 1'b1,
      '{4'd2, STATUS_OK, 1'b0, 8'sd127, STEPS_14, 16'h00C3, 5'd4}},
    // Unset accessory stores the inverted low byte under an all-ones high byte.
    '{'{CMD_UNSET_ACC, 14'd100, 8'sd0, 8'd0, 16'h00F0, 1'b1}, 1'b1,
      '{4'd3, STATUS_OK, 1'b1, 8'sd0, 8'd0, 16'hFF0F, 5'd4}},
    '{'{CMD_UNSET_ACC, 14'h3FFF, 8'sd0, 8'd0, 16'hFFFF, 1'b0}, 1'b1,
      '{4'd1, STATUS_REFUSED, 1'b1, -8'sd128, STEPS_128, 16'h0000, 5'd4}},
    '{'{CMD_ESTOP_ONE, 14'h3FFF, 8'sd0, 8'd0, 16'h0000, 1'b1}, 1'b1,
      '{4'd1, STATUS_OK, 1'b1, 8'sd0, STEPS_128, 16'h0000, 5'd4}},
    '{'{CMD_ESTOP_ONE, 14'd99, 8'sd0, 8'd0, 16'h0000, 1'b0}, 1'b1,
      '{4'd2, STATUS_REFUSED, 1'b0, 8'sd127, STEPS_14, 16'h00C3, 5'd4}},
    '{'{CMD_SET_SPEED, 14'd100, 8'sd55, 8'd255, 16'h0000, 1'b1}, 1'b0, NO_WANT},
    '{'{CMD_SET_SPEED, 14'h1555, 8'sh55, 8'd127, 16'h5555, 1'b1}, 1'b0, NO_WANT},
    '{'{CMD_SET_SPEED, 14'h2AAA, -8'sd86, 8'd129, 16'hAAAA, 1'b0}, 1'b0, NO_WANT},
    '{'{CMD_SET_SPEED, 14'h2AAA, 8'sh55, STEPS_28, 16'h0000, 1'b1}, 1'b0, NO_WANT},
    '{'{CMD_SET_FUNC, 14'd0, 8'sd0, 8'd0, 16'h5A5A, 1'b0}, 1'b0, NO_WANT},
    '{'{CMD_ESTOP_ALL, 14'h3FFF, 8'sd0, 8'd0, 16'h0000, 1'b0}, 1'b0, NO_WANT},
    '{'{CMD_SET_SPEED, 14'd99, -8'sd1, STEPS_128, 16'h0000, 1'b1}, 1'b0, NO_WANT},
    // Clear reports all zeros whatever the other fields hold.
    '{'{CMD_CLEAR, 14'h3FFF, -8'sd1, 8'd255, 16'hFFFF, 1'b0}, 1'b1,
      '{4'd0, STATUS_OK, 1'b0, 8'sd0, 8'd0, 16'h0000, 5'd0}},
    // After a clear the table appends from slot zero again with a zeroed entry.
    '{'{CMD_LOOKUP, 14'h3FFF, 8'sd0, 8'd0, 16'h0000, 1'b1}, 1'b1,
      '{4'd0, STATUS_OK, 1'b1, 8'sd0, 8'd0, 16'h0000, 5'd1}},
    '{'{CMD_ESTOP_ALL, 14'd0, 8'sd0, 8'd0, 16'h0000, 1'b1}, 1'b0, NO_WANT},
    '{'{CMD_SET_ACC, 14'h3FFE, 8'sd0, 8'd0, 16'hFF00, 1'b0}, 1'b0, NO_WANT}
  };

  // ---------------------------------------------------------------------------
  // Traffic shaping shared by the sender and the receiver. The sender sets these; the
  // receiver also writes hold_req and hold_cnt when it starts and counts down a hold-off.
  // ---------------------------------------------------------------------------
  logic quiet = 1'b0;
  int gap_pct = 20;
  int stall_pct = 20;
  logic hold_req = 1'b0;
  int hold_cnt = 0;

  // Address pool of the current episode. Small pools give many hits; pools larger
  // than the table force zero-slot reuse and round-robin replacement.
  logic [13:0] addr_pool [64];
  int pool_n = 1;

  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    logic [31:0] rnd;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) b.cmd = CMD_LOOKUP;
    else if (pick < 40) b.cmd = CMD_SET_SPEED;
    else if (pick < 55) b.cmd = CMD_SET_FUNC;
    else if (pick < 66) b.cmd = CMD_SET_ACC;
    else if (pick < 77) b.cmd = CMD_UNSET_ACC;
    else if (pick < 90) b.cmd = CMD_ESTOP_ONE;
    else if (pick < 99) b.cmd = CMD_ESTOP_ALL;
    else b.cmd = CMD_CLEAR;
    // Mostly pool addresses; a tenth of the traffic is any address at all.
    if ($urandom_range(0, 9) != 0) b.addr = addr_pool[$urandom_range(0, pool_n - 1)];
    else b.addr = 14'($urandom_range(0, 16383));
    rnd = $urandom;
    b.speed = rnd[7:0];
    b.funcs = rnd[31:16];
    // Legal step counts dominate; the rest is noise that exercises the reject path.
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 2))
        0: b.steps = STEPS_14;
        1: b.steps = STEPS_28;
        default: b.steps = STEPS_128;
      endcase
    end else begin
      b.steps = rnd[15:8];
    end
    b.ok = ($urandom_range(0, 99) < 85);
    return b;
  endfunction

  // Drive one command beat from the falling edge and hold it until accepted.
  // The expectation is recorded at the accepting rising edge.
  task automatic drive_beat(cmd_beat_t b, logic known, result_t want);
    result_t predicted;
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= b.cmd;
    cmd_ch.decoder_address <= b.addr;
    cmd_ch.speed_value <= b.speed;
    cmd_ch.step_mode <= b.steps;
    cmd_ch.function_bits <= b.funcs;
    cmd_ch.scheduler_ok <= b.ok;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    // The predictor always runs so its table stays in step with the block.
    predicted = predict_beat(b);
    expected_results.push_back(known ? want : predicted);
  endtask

  // Optional idle burst on the command side. Suppressed in the quiet tail and
  // while the receiver holds off, so the block really backs up.
  task automatic sender_gap();
    int g;
    if (!quiet && !hold_req && hold_cnt == 0 && $urandom_range(0, 99) < gap_pct) begin
      g = $urandom_range(1, 17);
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: reset, directed table, then random episodes.
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    int row;
    int episode_left;
    int waited;
    int k;
    logic no_zero;
    cmd_beat_t b;

    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_LOOKUP;
    cmd_ch.decoder_address = '0;
    cmd_ch.speed_value = '0;
    cmd_ch.step_mode = '0;
    cmd_ch.function_bits = '0;
    cmd_ch.scheduler_ok = 1'b0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    for (row = 0; row < N_DIRECTED; row++) begin
      drive_beat(directed_rows[row].beat, directed_rows[row].known, directed_rows[row].want);
      sender_gap();
    end

    episode_left = 0;
    for (n = 0; n < N_RANDOM; n++) begin
      if (episode_left == 0) begin
        // New episode: fresh address pool and fresh idle rates. Rates of zero give
        // long stretches with no idling at all.
        case ($urandom_range(0, 7))
          0: pool_n = 2;
          1: pool_n = 6;
          2: pool_n = 15;
          3: pool_n = 16;
          4: pool_n = 17;
          5: pool_n = 20;
          6: pool_n = 30;
          default: pool_n = 64;
        endcase
        no_zero = 1'($urandom_range(0, 1));
        for (k = 0; k < pool_n; k++) begin
          case ($urandom_range(0, 9))
            0: addr_pool[k] = no_zero ? 14'd1 : 14'd0;
            1: addr_pool[k] = 14'd99;
            2: addr_pool[k] = 14'd100;
            3: addr_pool[k] = 14'h3FFF;
            4, 5: addr_pool[k] = 14'($urandom_range(1, 199));
            default: addr_pool[k] = 14'($urandom_range(1, 16383));
          endcase
        end
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
        episode_left = $urandom_range(20, 120);
      end
      episode_left--;

      b = random_beat();
      // A quarter of the episodes start from an empty table.
      if (episode_left == 0 && $urandom_range(0, 3) == 0) b.cmd = CMD_CLEAR;
      drive_beat(b, 1'b0, NO_WANT);

      if (n == HOLD_AT) hold_req = 1'b1;
      if (n >= N_RANDOM - QUIET_TAIL) quiet = 1'b1;

      if (n == PAUSE_AT) begin
        // Let the block drain completely before the next command.
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end else begin
        sender_gap();
      end
    end

    @(negedge clk);
    cmd_ch.valid <= 1'b0;

    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // Any stray result after the last expected one is still caught here.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge. Random stall bursts, one long
  // hold-off on request, and none at all in the quiet tail.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_cnt;
    stall_cnt = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        stall_cnt = $urandom_range(1, 17) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result beat is compared field by field with
  // the oldest outstanding expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.slot_index, rsp_ch.status, rsp_ch.long_form, rsp_ch.entry_speed,
              rsp_ch.entry_steps, rsp_ch.entry_functions, rsp_ch.entry_count};
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result beat at %0t: slot %0d status %0d", $realtime,
                   got.slot_index, got.status);
        end
      end else begin
        want = expected_results.pop_front();
        if (got.slot_index !== want.slot_index || got.status !== want.status ||
            got.long_form !== want.long_form || got.entry_speed !== want.entry_speed ||
            got.entry_steps !== want.entry_steps ||
            got.entry_functions !== want.entry_functions ||
            got.entry_count !== want.entry_count) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at %0t (expected/actual): slot %0d/%0d status %0d/%0d",
                     $realtime, want.slot_index, got.slot_index, want.status, got.status);
            $display("  long %0d/%0d speed %0d/%0d steps %0d/%0d",
                     want.long_form, got.long_form, want.entry_speed, got.entry_speed,
                     want.entry_steps, got.entry_steps);
            $display("  functions %h/%h count %0d/%0d",
                     want.entry_functions, got.entry_functions,
                     want.entry_count, got.entry_count);
          end
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #6000000;
    $display("FAIL");
    $finish;
  end

endmodule
